// ===== hw/rtl/ldt_pkg.sv =====
package ldt_pkg;

   // configuration register width and reset value
   localparam int CSR_W = 7;
   localparam logic [CSR_W-1:0] SEG_LEN_RESET = 7'd64;

   // width of the sample index port
   localparam int IDX_OUT_W = 6;

   // controller states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SINGLE,
      ST_PRE1,
      ST_PRE2,
      ST_READ,
      ST_MULT,
      ST_NUM,
      ST_ABS,
      ST_DSTART,
      ST_DIV,
      ST_OUT
   } ldt_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic pre1;
      logic pre2;
      logic mem_read;
      logic mult;
      logic num;
      logic absval;
      logic div_start;
      logic out_load;
      logic out_single;
      logic idx_inc;
   } ldt_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic close;
      logic single;
      logic last;
      logic div_busy;
      logic div_done;
   } ldt_status_type;

endpackage

// ===== hw/rtl/ldt_divider.sv =====
module ldt_divider #(
   parameter int QUOT_BITS = 17,
   parameter int MAG_W     = 45,
   parameter int DEN_W     = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_W-1:0]     mag,
   input  logic [DEN_W-1:0]     den,
   output logic [QUOT_BITS-1:0] quot,
   output logic                 busy,
   output logic                 done
);
   import ldt_pkg::*;

   localparam int RW = MAG_W + 2;
   localparam int CW = (QUOT_BITS > 1) ? $clog2(QUOT_BITS) : 1;

   logic [RW-1:0]        rem_ff, rem_in;
   logic [RW-1:0]        dsh_ff, dsh_in;
   logic [QUOT_BITS-1:0] quot_ff, quot_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   // restoring division of (2*mag + den) by (2*den), one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = (RW'(mag) << 1) + RW'(den);
         dsh_in  = (RW'(den) << 1) << (QUOT_BITS - 1);
         quot_in = '0;
         cnt_in  = CW'(QUOT_BITS - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign quot = quot_ff;
   assign busy = busy_ff;
   assign done = done_ff;

   // a started division is running and not yet finished
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && !done_ff))
      else $error("divider did not start");

endmodule

// ===== hw/rtl/ldt_datapath.sv =====
module ldt_datapath #(
   parameter int MAX_SEGMENT = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ldt_pkg::ldt_cmd_type                cmd,
   output ldt_pkg::ldt_status_type             status,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                csr_wr_en,
   input  logic [ldt_pkg::CSR_W-1:0]           csr_wr_data,
   output logic signed [SAMPLE_BITS-1:0]       rsp_residual,
   output logic [ldt_pkg::IDX_OUT_W-1:0]       rsp_sample_index,
   output logic                                rsp_segment_end
);
   import ldt_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int IW    = $clog2(MAX_SEGMENT);
   localparam int LW    = $clog2(MAX_SEGMENT + 1);
   localparam int SQ    = 2 * LW;
   localparam int DW    = 3 * LW;
   localparam int SW    = SB + LW;
   localparam int WW    = SB + 2 * LW;
   localparam int MSW   = SW + LW + 1;
   localparam int KW    = SB + 2 * LW + 4;
   localparam int FW    = LW + 2;
   localparam int XDW   = SB + DW + 1;
   localparam int SMW   = SW + SQ + 1;
   localparam int KTW   = KW + FW;
   localparam int NUM_W = SB + 3 * LW + 8;
   localparam int CMP_W = CSR_W + 1;

   localparam logic [SB:0]   HALF    = {2'b01, {(SB - 1){1'b0}}};
   localparam logic [SB-1:0] POS_MAX = {1'b0, {(SB - 1){1'b1}}};
   localparam logic [SB-1:0] NEG_MIN = {1'b1, {(SB - 1){1'b0}}};

   // configuration and accumulation state
   logic [CSR_W-1:0]     seg_len_ff, seg_len_in;
   logic [IW-1:0]        fill_ff, fill_in;
   logic signed [SW-1:0] acc_s_ff, acc_s_in;
   logic signed [WW-1:0] acc_w_ff, acc_w_in;
   logic [IW-1:0]        idx_ff, idx_in;

   // per-segment values
   logic signed [SW-1:0]  seg_s_ff;
   logic signed [WW-1:0]  seg_w_ff;
   logic [LW-1:0]         m_ff;
   logic signed [SB-1:0]  last_x_ff;
   logic [SQ-1:0]         msq1_ff;
   logic signed [MSW-1:0] ms_ff;
   logic [DW-1:0]         den_ff;
   logic signed [SMW-1:0] sm_ff;
   logic signed [KW-1:0]  k_ff;

   // per-residual values
   logic signed [SB-1:0]    mem_q_ff;
   logic signed [XDW-1:0]   xd_ff;
   logic signed [KTW-1:0]   kt_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0]        mag_ff;
   logic                    neg_ff;

   // output registers
   logic signed [SB-1:0]   res_out_ff;
   logic [IDX_OUT_W-1:0]   idx_out_ff;
   logic                   end_out_ff;

   logic signed [SB-1:0] mem [MAX_SEGMENT];

   logic [CMP_W-1:0]      n_eff;
   logic [CMP_W-1:0]      fill_plus;
   logic                  close;
   logic signed [SW-1:0]  s_next;
   logic signed [WW-1:0]  w_next;
   logic signed [IW+SB:0] pos_prod;
   logic                  last;
   logic signed [FW-1:0]  f_val;
   logic signed [KW-1:0]  k_diff;
   logic signed [XDW-1:0] xd_prod;
   logic signed [KTW-1:0] kt_prod;
   logic signed [SMW-1:0] sm_prod;
   logic signed [MSW-1:0] ms_prod;
   logic signed [NUM_W-1:0] num_val;
   logic [SB:0]           quot;
   logic [SB:0]           quot_neg;
   logic signed [SB-1:0]  res_val;
   logic                  div_busy;
   logic                  div_done;

   // effective segment length, clamped to 1..MAX_SEGMENT
   always_comb begin
      if (seg_len_ff == '0) begin
         n_eff = CMP_W'(1);
      end else if (CMP_W'(seg_len_ff) > CMP_W'(MAX_SEGMENT)) begin
         n_eff = CMP_W'(MAX_SEGMENT);
      end else begin
         n_eff = CMP_W'(seg_len_ff);
      end
   end

   // segment close and running sums
   assign fill_plus = CMP_W'(fill_ff) + CMP_W'(1);
   assign close     = fill_plus >= n_eff;
   assign pos_prod  = $signed({1'b0, fill_ff}) * req_sample;
   assign s_next    = acc_s_ff + SW'(req_sample);
   assign w_next    = acc_w_ff + WW'(pos_prod);
   assign last      = (LW'(idx_ff) + LW'(1)) == m_ff;

   always_comb begin
      seg_len_in = csr_wr_en ? csr_wr_data : seg_len_ff;
      fill_in    = fill_ff;
      acc_s_in   = acc_s_ff;
      acc_w_in   = acc_w_ff;
      if (cmd.accept) begin
         if (close) begin
            fill_in  = '0;
            acc_s_in = '0;
            acc_w_in = '0;
         end else begin
            fill_in  = fill_ff + IW'(1);
            acc_s_in = s_next;
            acc_w_in = w_next;
         end
      end
   end

   // residual counter
   always_comb begin
      idx_in = idx_ff;
      if (cmd.pre1) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff <= SEG_LEN_RESET;
         fill_ff    <= '0;
         acc_s_ff   <= '0;
         acc_w_ff   <= '0;
         idx_ff     <= '0;
      end else begin
         seg_len_ff <= seg_len_in;
         fill_ff    <= fill_in;
         acc_s_ff   <= acc_s_in;
         acc_w_ff   <= acc_w_in;
         idx_ff     <= idx_in;
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[fill_ff] <= req_sample;
      end
      if (cmd.mem_read) begin
         mem_q_ff <= mem[idx_ff];
      end
   end

   // capture of the closed segment
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_x_ff <= req_sample;
         if (close) begin
            seg_s_ff <= s_next;
            seg_w_ff <= w_next;
            m_ff     <= LW'(fill_plus);
         end
      end
   end

   // line fit constants: m^2-1, (m-1)*S, then D, S*(m^2-1) and K
   assign ms_prod = $signed({1'b0, m_ff - LW'(1)}) * seg_s_ff;
   assign sm_prod = seg_s_ff * $signed({1'b0, msq1_ff});
   assign k_diff  = (KW'(seg_w_ff) <<< 1) - KW'(ms_ff);

   always_ff @(posedge clock) begin
      if (cmd.pre1) begin
         msq1_ff <= SQ'(m_ff * m_ff) - SQ'(1);
         ms_ff   <= ms_prod;
      end
      if (cmd.pre2) begin
         den_ff <= DW'(m_ff * msq1_ff);
         sm_ff  <= sm_prod;
         k_ff   <= (k_diff <<< 1) + k_diff;
      end
   end

   // residual numerator: x_i*D - S*(m^2-1) - K*(2i-m+1)
   assign f_val   = $signed((FW'(idx_ff) << 1) + FW'(1) - FW'(m_ff));
   assign xd_prod = mem_q_ff * $signed({1'b0, den_ff});
   assign kt_prod = k_ff * f_val;
   assign num_val = NUM_W'(xd_ff) - NUM_W'(sm_ff) - NUM_W'(kt_ff);

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         xd_ff <= xd_prod;
         kt_ff <= kt_prod;
      end
      if (cmd.num) begin
         num_ff <= num_val;
      end
      if (cmd.absval) begin
         neg_ff <= num_ff[NUM_W-1];
         mag_ff <= num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
      end
   end

   // rounding divider
   ldt_divider #(
      .QUOT_BITS (SB + 1),
      .MAG_W     (NUM_W),
      .DEN_W     (DW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .mag   (mag_ff),
      .den   (den_ff),
      .quot  (quot),
      .busy  (div_busy),
      .done  (div_done)
   );

   // sign and saturation of the rounded quotient
   assign quot_neg = (~quot) + (SB + 1)'(1);

   always_comb begin
      if (!neg_ff) begin
         res_val = (quot >= HALF) ? POS_MAX : quot[SB-1:0];
      end else begin
         res_val = (quot > HALF) ? NEG_MIN : quot_neg[SB-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_single) begin
         res_out_ff <= last_x_ff;
         idx_out_ff <= '0;
         end_out_ff <= 1'b1;
      end else if (cmd.out_load) begin
         res_out_ff <= res_val;
         idx_out_ff <= IDX_OUT_W'(idx_ff);
         end_out_ff <= last;
      end
   end

   assign rsp_residual     = res_out_ff;
   assign rsp_sample_index = idx_out_ff;
   assign rsp_segment_end  = end_out_ff;

   // status to controller
   always_comb begin
      status.close    = close;
      status.single   = close && (fill_ff == '0);
      status.last     = last;
      status.div_busy = div_busy;
      status.div_done = div_done;
   end

endmodule

// ===== hw/rtl/ldt_controller.sv =====
module ldt_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ldt_pkg::ldt_cmd_type    cmd,
   input  ldt_pkg::ldt_status_type status
);
   import ldt_pkg::*;

   ldt_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && status.close) begin
               state_in = status.single ? ST_SINGLE : ST_PRE1;
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         ST_PRE1:   state_in = ST_PRE2;
         ST_PRE2:   state_in = ST_READ;
         ST_READ:   state_in = ST_MULT;
         ST_MULT:   state_in = ST_NUM;
         ST_NUM:    state_in = ST_ABS;
         ST_ABS:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = status.last ? ST_LOAD : ST_READ;
            end
         end
         default:   state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SINGLE: cmd.out_single = out_free;
         ST_PRE1:   cmd.pre1       = 1'b1;
         ST_PRE2:   cmd.pre2       = 1'b1;
         ST_READ:   cmd.mem_read   = 1'b1;
         ST_MULT:   cmd.mult       = 1'b1;
         ST_NUM:    cmd.num        = 1'b1;
         ST_ABS:    cmd.absval     = 1'b1;
         ST_DSTART: cmd.div_start  = 1'b1;
         ST_DIV: begin
         end
         ST_OUT: begin
            cmd.out_load = out_free;
            cmd.idx_inc  = out_free && !status.last;
         end
         default: begin
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.out_load || cmd.out_single) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.out_single) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   // closing request stops intake until the segment is emitted
   a_close_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.close) |=> !req_ready)
      else $error("request taken during emission");

   // divider is never restarted while running
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider restarted while busy");

endmodule

// ===== hw/rtl/linear_detrend_segment_top.sv =====
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_sample
// rsp       out        rsp_valid/rsp_ready    rsp_residual, rsp_sample_index, rsp_segment_end
// csr       in         csr_wr_en              csr_wr_data (segment length)
//
// a request is taken each cycle while a segment fills; the request that closes a
// segment of m samples starts two setup states (PRE1, PRE2), then each residual passes
// through read, multiply, numerator, absolute value and the bit-serial rounding divider.
// a segment of one sample is returned through the single state once the result register is free.
// reset is synchronous, active high, clears counters and sums; sample store is not cleared.
// a stalled rsp holds the result register and the sequencer in its output or single state; new requests are taken
// meanwhile once the last residual of a segment is loaded.
module linear_detrend_segment_top #(
   parameter int MAX_SEGMENT = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_residual,
   output logic [ldt_pkg::IDX_OUT_W-1:0] rsp_sample_index,
   output logic                          rsp_segment_end,
   input  logic                          csr_wr_en,
   input  logic [ldt_pkg::CSR_W-1:0]     csr_wr_data
);
   import ldt_pkg::*;

   ldt_cmd_type    cmd;
   ldt_status_type status;

   // sequencing
   ldt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // storage, sums, fit and division
   ldt_datapath #(
      .MAX_SEGMENT (MAX_SEGMENT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_residual     (rsp_residual),
      .rsp_sample_index (rsp_sample_index),
      .rsp_segment_end  (rsp_segment_end)
   );

endmodule

// ===== test/testbench.sv =====
module testbench;

   import ldt_pkg::*;

   localparam int MAX_SEGMENT = 64;
   localparam int SAMPLE_BITS = 16;
   localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
   localparam int GAP_MAX = 14;
   localparam int HOLD_CYCLES = 400;
   // idle margin after the last result
   localparam int SETTLE_CYCLES = 2 * (SAMPLE_BITS + 8) + 4;
   localparam int QUIET_LIMIT = 3000;
   localparam int ITEM_TARGET = 330;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] residual;
      logic [IDX_OUT_W-1:0]          index;
      logic                          last;
   } residual_type;

   typedef enum int {
      PAT_FULL,
      PAT_SMALL,
      PAT_EXTREME,
      PAT_RAMP
   } sample_pattern_type;

   // running least-squares detrend: keeps its own segment and the residuals it owes
   class detrend_scoreboard;
      logic [CSR_W-1:0] seg_length;
      longint           fill;
      longint           value_sum;
      longint           weighted_sum;
      longint           store[MAX_SEGMENT];
      residual_type     pending[$];
      int               failures;
      int               checked;
      int               segments;

      function new();
         seg_length = SEG_LEN_RESET;
         fill = 0;
         value_sum = 0;
         weighted_sum = 0;
         failures = 0;
         checked = 0;
         segments = 0;
      endfunction

      function void set_length(logic [CSR_W-1:0] len);
         seg_length = len;
      endfunction

      function bit empty();
         return pending.size() == 0;
      endfunction

      // divide with ties away from zero, then clip to the sample range
      function logic signed [SAMPLE_BITS-1:0] round_residual(longint num, longint den);
         longint mag;
         longint q;
         mag = (num < 0) ? -num : num;
         q = (2 * mag + den) / (2 * den);
         if (num < 0) q = -q;
         if (q > SAMPLE_MAX) q = SAMPLE_MAX;
         if (q < SAMPLE_MIN) q = SAMPLE_MIN;
         return q[SAMPLE_BITS-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_BITS-1:0] value);
         longint n;
         longint pos;
         longint x;
         longint m;
         longint s;
         longint w;
         longint k;
         longint den;
         longint fit;
         residual_type rec;
         n = seg_length;
         if (n < 1) n = 1;
         if (n > MAX_SEGMENT) n = MAX_SEGMENT;
         pos = fill;
         if (pos >= MAX_SEGMENT) pos = MAX_SEGMENT - 1;
         x = value;
         store[pos] = x;
         value_sum += x;
         weighted_sum += pos * x;
         if (pos + 1 < n) begin
            fill = pos + 1;
            return;
         end
         // segment closes here
         m = pos + 1;
         s = value_sum;
         w = weighted_sum;
         fill = 0;
         value_sum = 0;
         weighted_sum = 0;
         if (m == 1) begin
            rec.residual = value;
            rec.index = '0;
            rec.last = 1'b1;
            pending.push_back(rec);
            return;
         end
         den = m * (m * m - 1);
         k = 3 * (2 * w - (m - 1) * s);
         for (longint i = 0; i < m; i++) begin
            fit = s * (m * m - 1) + k * (2 * i - m + 1);
            rec.residual = round_residual(store[i] * den - fit, den);
            rec.index = i[IDX_OUT_W-1:0];
            rec.last = (i + 1 == m);
            pending.push_back(rec);
         end
      endfunction

      function void check_result(residual_type got);
         residual_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected residual %0d at index %0d, nothing expected",
                     $time, got.residual, got.index);
            failures++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.last) segments++;
         if (got.residual !== want.residual) begin
            $display("%0t: residual at index %0d expected %0d, actual %0d",
                     $time, want.index, want.residual, got.residual);
            failures++;
         end
         if (got.index !== want.index) begin
            $display("%0t: sample index expected %0d, actual %0d",
                     $time, want.index, got.index);
            failures++;
         end
         if (got.last !== want.last) begin
            $display("%0t: segment end at index %0d expected %0b, actual %0b",
                     $time, want.index, want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_residual;
   logic [IDX_OUT_W-1:0]          rsp_sample_index;
   logic                          rsp_segment_end;
   logic                          csr_wr_en = 1'b0;
   logic [CSR_W-1:0]              csr_wr_data = '0;

   detrend_scoreboard board;
   bit                req_eager = 1'b0;
   bit                rsp_eager = 1'b0;
   bit                long_hold = 1'b0;
   int                sent_count = 0;
   int                length_writes = 0;
   int                quiet_cycles = 0;

   linear_detrend_segment_top #(
      .MAX_SEGMENT(MAX_SEGMENT),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_residual    (rsp_residual),
      .rsp_sample_index(rsp_sample_index),
      .rsp_segment_end (rsp_segment_end),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one request, after a random idle gap unless req_eager is set
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      board.note_sample(value);
      sent_count++;
   endtask

   task automatic send_batch(input int values[$]);
      foreach (values[i]) send_sample(values[i][SAMPLE_BITS-1:0]);
   endtask

   task automatic write_length(input logic [CSR_W-1:0] len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_length(len);
      length_writes++;
   endtask

   // wait for every owed residual, then let the block return to loading
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!board.empty()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(
      sample_pattern_type kind, int i, int base, int slope);
      int v;
      case (kind)
         PAT_FULL: v = int'($urandom_range(0, 65535)) - 32768;
         PAT_SMALL: v = int'($urandom_range(0, 512)) - 256;
         PAT_EXTREME: begin
            case ($urandom_range(0, 3))
               0: v = int'(SAMPLE_MIN);
               1: v = int'(SAMPLE_MAX);
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            // noisy straight line, clipped
            v = base + slope * i + int'($urandom_range(0, 16)) - 8;
            if (v > SAMPLE_MAX) v = int'(SAMPLE_MAX);
            if (v < SAMPLE_MIN) v = int'(SAMPLE_MIN);
         end
      endcase
      return v[SAMPLE_BITS-1:0];
   endfunction

   // result side: random stalls unless rsp_eager is set, one long hold when asked
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold) begin
            gap = HOLD_CYCLES;
            long_hold = 1'b0;
         end else if (rsp_eager) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, GAP_MAX);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // result checking
   always @(posedge clock) begin
      residual_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.residual = rsp_residual;
         got.index = rsp_sample_index;
         got.last = rsp_segment_end;
         board.check_result(got);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("testbench failed");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int            batch[$];
      int            phase;
      int            pick;
      int            eff;
      int            reps;
      int            n_items;
      int            base;
      int            slope;
      int            big_phases;
      logic [CSR_W-1:0] len;
      sample_pattern_type pat;
      board = new();
      phase = 0;
      big_phases = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // partial fill at the reset length, then shorten to the fill level
      batch = '{32767, -32768, 0};
      send_batch(batch);
      settle();
      write_length(7'd3);
      batch = '{12345};
      send_batch(batch);

      // unit length returns samples unchanged
      settle();
      write_length(7'd1);
      batch = '{-32768, 32767, 0, -1, 1};
      send_batch(batch);

      // zero length acts as one
      settle();
      write_length(7'd0);
      batch = '{21845, -21846};
      send_batch(batch);

      // zigzag at full scale saturates both ways
      settle();
      write_length(7'd3);
      batch = '{32767, -32768, 32767, -32768, 32767, -32768};
      send_batch(batch);

      // two points always fit exactly
      settle();
      write_length(7'd2);
      batch = '{32767, -32768, -1, 0};
      send_batch(batch);

      // random segments of mixed lengths and shapes
      while (sent_count < ITEM_TARGET) begin
         settle();
         case (phase)
            0: len = 7'd3;
            1: len = 7'd127;
            2: len = 7'd64;
            default: begin
               pick = $urandom_range(0, 15);
               if (pick == 0) len = 7'd0;
               else if (pick == 1) len = 7'd1;
               else if (pick <= 10) len = 7'($urandom_range(2, 8));
               else if (pick <= 13) len = 7'($urandom_range(9, 20));
               else if (big_phases < 1) begin
                  len = 7'($urandom_range(21, 127));
                  big_phases++;
               end else len = 7'($urandom_range(2, 6));
            end
         endcase
         write_length(len);
         eff = (len == 0) ? 1 : (len > MAX_SEGMENT) ? MAX_SEGMENT : int'(len);
         reps = (phase == 0) ? 10 : (eff <= 8) ? $urandom_range(1, 4) : 1;
         n_items = reps * eff;
         // sometimes leave a partial segment for the next setting
         if ($urandom_range(0, 3) == 0) n_items += $urandom_range(0, eff - 1);
         req_eager = (phase == 0) || ($urandom_range(0, 3) == 0);
         rsp_eager = (phase != 0) && ($urandom_range(0, 3) == 0);
         if (phase == 0) long_hold = 1'b1;
         pat = sample_pattern_type'($urandom_range(0, 3));
         base = int'($urandom_range(0, 40000)) - 20000;
         slope = int'($urandom_range(0, 2000)) - 1000;
         for (int i = 0; i < n_items; i++) send_sample(draw_sample(pat, i, base, slope));
         phase++;
      end

      settle();
      $display("run summary: %0d samples under %0d length writes, %0d residuals in %0d segments",
               sent_count, length_writes, board.checked, board.segments);
      $display("lengths 0 to 127, shortening mid-segment, saturation, a %0d-cycle result hold",
               HOLD_CYCLES);
      if (board.failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
